@@ rtl/core/stdp_pkg.sv @@
`default_nettype none

package stdp_pkg;

  // Table geometry
  localparam int SYNAPSES          = 1024;
  localparam int SYN_W             = 10;
  localparam int SYN_AW_RAW        = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int SYN_AW            = (SYN_AW_RAW > SYN_W) ? SYN_W : SYN_AW_RAW;

  // Decay tables
  localparam int DECAY_TABLE_DEPTH = 1024;
  localparam int DEC_AW            = $clog2(DECAY_TABLE_DEPTH);
  localparam int DEC_W             = 17;
  localparam int TAU_POS_TICKS     = 200;
  localparam int TAU_NEG_TICKS     = 200;

  localparam longint unsigned ONE_Q31 = 64'd1 << 31;
  localparam longint unsigned X_POS   =
    (ONE_Q31 + longint'(TAU_POS_TICKS / 2)) / longint'(TAU_POS_TICKS);
  localparam longint unsigned X_NEG   =
    (ONE_Q31 + longint'(TAU_NEG_TICKS / 2)) / longint'(TAU_NEG_TICKS);

  // Event kinds
  localparam logic [1:0] KIND_PRE    = 2'd0;
  localparam logic [1:0] KIND_POST   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_LOAD   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_PLASTIC_ENABLE = 3'd0;
  localparam logic [2:0] REG_WEIGHT_MAX     = 3'd1;
  localparam logic [2:0] REG_WEIGHT_MIN     = 3'd2;
  localparam logic [2:0] REG_AMP_POS        = 3'd3;
  localparam logic [2:0] REG_AMP_NEG        = 3'd4;
  localparam logic [2:0] REG_DRIFT_CONST    = 3'd5;
  localparam logic [2:0] REG_CHANGE_FILTER  = 3'd6;

  localparam logic [DEC_W-1:0] FILTER_ONE = 17'd65536;

  typedef logic [DEC_W-1:0] decay_tab_t [DECAY_TABLE_DEPTH];

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] change;
    logic signed [31:0] pre_trace;
    logic signed [31:0] post_trace;
    logic [31:0]        pre_time;
    logic [31:0]        post_time;
  } row_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Unsigned quotient by shift and subtract; evaluated at elaboration
  function automatic longint unsigned udiv_shift(input longint unsigned n,
                                                 input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Build exp(-d/tau) in Q1.16, from x = 1/tau in Q31; evaluated at elaboration
  function automatic decay_tab_t build_decay(input longint unsigned x);
    decay_tab_t      t;
    longint unsigned term;
    longint unsigned f;
    longint unsigned acc;
    longint          sum;
    term = ONE_Q31;
    sum  = longint'(ONE_Q31);
    for (int k = 1; k <= 24; k++) begin
      term = udiv_shift((term * x) >> 31, 64'(k));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q31)) begin
      sum = longint'(ONE_Q31);
    end
    f   = longint'(sum);
    acc = ONE_Q31;
    for (int d = 0; d < DECAY_TABLE_DEPTH; d++) begin
      t[d] = DEC_W'((acc + 64'd16384) >> 15);
      acc  = (acc * f + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/stdp_decay_rom.sv @@
`default_nettype none

module stdp_decay_rom
  import stdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [DEC_AW-1:0] addr,
  output logic      [DEC_W-1:0]  pos_q,
  output logic      [DEC_W-1:0]  neg_q
);

  localparam decay_tab_t POS_TAB = build_decay(X_POS);
  localparam decay_tab_t NEG_TAB = build_decay(X_NEG);

  // Registered read of both tables at the same distance
  always_ff @(posedge clk) begin
    pos_q <= POS_TAB[addr];
    neg_q <= NEG_TAB[addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/stdp_scale_unit.sv @@
`default_nettype none

module stdp_scale_unit
  import stdp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] value,
  input  wire logic [DEC_W-1:0]   factor,
  output logic signed [31:0]      scaled
);

  logic signed [49:0] prod_q;
  logic signed [17:0] factor_s;

  assign factor_s = $signed({1'b0, factor});

  // Multiply and add the rounding half; floor on the shift gives round half up
  always_ff @(posedge clk) begin
    prod_q <= 50'(value) * 50'(factor_s) + 50'sd32768;
  end

  assign scaled = sat32(prod_q[49:16]);

endmodule

`default_nettype wire

@@ rtl/core/stdp_synapse_table_unit.sv @@
`default_nettype none

// STDP synapse table: one row per synapse holding weight, pending change,
// pre and post traces and the last pre and post spike times.
//
// Command channel: present kind, synapse, event_time and load_weight with
// start high; the transfer happens at a rising edge where busy is low.
// Kinds: pre spike (delivers the weight and learns), post spike (learns),
// periodic update (applies the change to the weight, then filters it) and
// load (initializes a row).
//
// Every command gives exactly one result: synapse_out, delivers and
// current_add are shown for one cycle with done high. The receiver cannot
// stall; the result is simply presented. The steps after the accepting edge
// (row read at that edge) are the decay table read, the shared multiply and
// the write back, which registers the result and raises done. The next
// command can be taken in the done cycle, so one command is in flight at a
// time, set by the four sequencer steps through one row port and one multiplier.
//
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while idle. Reset clears control state and loads register defaults; the
// row memory is not cleared, so rows must be loaded before use.

module stdp_synapse_table_unit
  import stdp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // command
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [SYN_W-1:0]   synapse,
  input  wire logic [31:0]        event_time,
  input  wire logic signed [31:0] load_weight,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // result
  output logic                    done,
  output logic [SYN_W-1:0]        synapse_out,
  output logic                    delivers,
  output logic signed [31:0]      current_add
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_MUL,
    S_WB
  } state_t;

  state_t state;

  // configuration registers
  logic               plastic_enable;
  logic signed [31:0] weight_max;
  logic signed [31:0] weight_min;
  logic signed [31:0] amp_pos;
  logic signed [31:0] amp_neg;
  logic signed [31:0] drift_const;
  logic [DEC_W-1:0]   change_filter;

  // captured command
  logic [1:0]         kind_q;
  logic [SYN_W-1:0]   syn_q;
  logic [31:0]        time_q;
  logic signed [31:0] load_q;
  logic               in_range_q;

  // row memory and its read register
  row_t               row_mem [SYNAPSES];
  row_t               row_q;
  row_t               row_next;
  logic               row_we;

  // datapath
  logic [31:0]        dt;
  logic               far_q;
  logic signed [33:0] wsum_q;
  logic signed [31:0] weight_clamped;
  logic [DEC_W-1:0]   dec_pos;
  logic [DEC_W-1:0]   dec_neg;
  logic [DEC_W-1:0]   filt;
  logic signed [31:0] mul_value;
  logic [DEC_W-1:0]   mul_factor;
  logic signed [31:0] tr;
  logic signed [31:0] change_sum;
  logic               deliver;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Elapsed time since the last spike of the other side
  assign dt = time_q - ((kind_q == KIND_PRE) ? row_q.post_time : row_q.pre_time);

  stdp_decay_rom u_rom (
    .clk   (clk),
    .addr  (dt[DEC_AW-1:0]),
    .pos_q (dec_pos),
    .neg_q (dec_neg)
  );

  // Operand select for the shared multiplier
  assign filt = (change_filter > FILTER_ONE) ? FILTER_ONE : change_filter;

  always_comb begin
    mul_value  = row_q.change;
    mul_factor = filt;
    case (kind_q)
      KIND_PRE: begin
        mul_value  = row_q.post_trace;
        mul_factor = far_q ? '0 : dec_neg;
      end
      KIND_POST: begin
        mul_value  = row_q.pre_trace;
        mul_factor = far_q ? '0 : dec_pos;
      end
      default: begin
        mul_value  = row_q.change;
        mul_factor = filt;
      end
    endcase
  end

  stdp_scale_unit u_scale (
    .clk    (clk),
    .value  (mul_value),
    .factor (mul_factor),
    .scaled (tr)
  );

  assign change_sum = sat32(34'(row_q.change) + 34'(tr));

  // Clamp: max wins over min
  always_comb begin
    if (wsum_q > 34'(weight_max)) begin
      weight_clamped = weight_max;
    end else if (wsum_q < 34'(weight_min)) begin
      weight_clamped = weight_min;
    end else begin
      weight_clamped = wsum_q[31:0];
    end
  end

  // Next row contents and write enable
  always_comb begin
    row_next = row_q;
    row_we   = 1'b0;
    case (kind_q)
      KIND_PRE: begin
        row_we              = in_range_q && plastic_enable;
        row_next.post_trace = tr;
        row_next.change     = change_sum;
        row_next.pre_trace  = amp_pos;
        row_next.pre_time   = time_q;
      end
      KIND_POST: begin
        row_we              = in_range_q && plastic_enable;
        row_next.pre_trace  = tr;
        row_next.change     = change_sum;
        row_next.post_trace = amp_neg;
        row_next.post_time  = time_q;
      end
      KIND_UPDATE: begin
        row_we          = in_range_q && plastic_enable;
        row_next.weight = weight_clamped;
        row_next.change = tr;
      end
      default: begin
        row_we              = in_range_q;
        row_next.weight     = load_q;
        row_next.change     = '0;
        row_next.pre_trace  = '0;
        row_next.post_trace = '0;
        row_next.pre_time   = time_q;
        row_next.post_time  = time_q;
      end
    endcase
  end

  assign deliver = in_range_q && (kind_q == KIND_PRE);

  // Row memory: read on the accepting edge, write back at the end
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      row_q <= row_mem[synapse[SYN_AW-1:0]];
    end
    if (state == S_WB && row_we) begin
      row_mem[syn_q[SYN_AW-1:0]] <= row_next;
    end
  end

  // Sequencer, configuration and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      plastic_enable <= 1'b1;
      weight_max     <= 32'sd65536;
      weight_min     <= 32'sd0;
      amp_pos        <= 32'sd655;
      amp_neg        <= -32'sd655;
      drift_const    <= 32'sd0;
      change_filter  <= 17'd58982;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PLASTIC_ENABLE: plastic_enable <= cfg_data[0];
          REG_WEIGHT_MAX:     weight_max     <= cfg_data;
          REG_WEIGHT_MIN:     weight_min     <= cfg_data;
          REG_AMP_POS:        amp_pos        <= cfg_data;
          REG_AMP_NEG:        amp_neg        <= cfg_data;
          REG_DRIFT_CONST:    drift_const    <= cfg_data;
          REG_CHANGE_FILTER:  change_filter  <= cfg_data[DEC_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            kind_q     <= kind;
            syn_q      <= synapse;
            time_q     <= event_time;
            load_q     <= load_weight;
            in_range_q <= (32'(synapse) < 32'(SYNAPSES));
            state      <= S_ROW;
          end
        end
        S_ROW: begin
          // decay table read is in flight; form the weight sum meanwhile
          far_q  <= (dt >= 32'(DECAY_TABLE_DEPTH));
          wsum_q <= 34'(row_q.weight) + 34'(row_q.change) + 34'(drift_const);
          state  <= S_MUL;
        end
        S_MUL: begin
          state <= S_WB;
        end
        S_WB: begin
          done        <= 1'b1;
          synapse_out <= syn_q;
          delivers    <= deliver;
          current_add <= deliver ? row_q.weight : 32'sd0;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/stdp_synapse_table_unit_tb.sv @@
module stdp_synapse_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stdp_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 185;

  // One expected result per accepted command.
  typedef struct {
    logic [SYN_W-1:0]   row;
    logic               dlv;
    logic signed [31:0] amount;
  } delivery_t;

  // Register settings that the random phases step through.
  typedef enum {
    SET_TYPICAL,
    SET_EXTREME_HIGH,
    SET_EXTREME_LOW,
    SET_INVERTED_CLAMP,
    SET_LEARNING_OFF,
    SET_ANY
  } setting_t;

  // Tracks the synapse rows and registers and queues the deliveries they imply.
  class synapse_table_tracker;
    logic signed [31:0] weight     [SYNAPSES];
    logic signed [31:0] change     [SYNAPSES];
    logic signed [31:0] pre_trace  [SYNAPSES];
    logic signed [31:0] post_trace [SYNAPSES];
    logic [31:0]        pre_stamp  [SYNAPSES];
    logic [31:0]        post_stamp [SYNAPSES];
    int unsigned        pre_decay  [DECAY_TABLE_DEPTH];
    int unsigned        post_decay [DECAY_TABLE_DEPTH];
    bit                 learn;
    logic signed [31:0] w_ceiling;
    logic signed [31:0] w_floor;
    logic signed [31:0] amp_pre;
    logic signed [31:0] amp_post;
    logic signed [31:0] drift;
    logic [16:0]        filter;
    delivery_t          expected_deliveries [$];
    int unsigned        mismatches;

    // exp(-1/tau) by alternating series in Q31, then powers of it rounded to Q1.16
    function void fill_decay(bit for_post, longint unsigned tau);
      longint unsigned x;
      longint unsigned term;
      longint unsigned step;
      longint unsigned acc;
      longint          sum;
      x    = ((64'd1 << 31) + tau / 2) / tau;
      term = 64'd1 << 31;
      sum  = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = ((term * x) >> 31) / longint'(k);
        sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > 64'sd2147483648) begin
        sum = 64'sd2147483648;
      end
      step = sum;
      acc  = 64'd1 << 31;
      for (int d = 0; d < DECAY_TABLE_DEPTH; d++) begin
        if (for_post) begin
          post_decay[d] = 32'((acc + 64'd16384) >> 15);
        end else begin
          pre_decay[d] = 32'((acc + 64'd16384) >> 15);
        end
        acc = (acc * step + (64'd1 << 30)) >> 31;
      end
    endfunction

    function new();
      fill_decay(1'b0, TAU_POS_TICKS);
      fill_decay(1'b1, TAU_NEG_TICKS);
      learn      = 1'b1;
      w_ceiling  = 32'sd65536;
      w_floor    = 32'sd0;
      amp_pre    = 32'sd655;
      amp_post   = -32'sd655;
      drift      = 32'sd0;
      filter     = 17'd58982;
      mismatches = 0;
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) begin
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // Q16.16 times Q1.16, rounded half toward +inf (floor of q + 1/2)
    function logic signed [31:0] scale(logic signed [31:0] v, int unsigned f);
      longint q;
      longint fl;
      fl = f;
      q  = longint'(v) * fl + 64'sd32768;
      return clip(q >>> 16);
    endfunction

    function int unsigned decay_at(bit for_post, logic [31:0] gap);
      if (gap >= DECAY_TABLE_DEPTH) begin
        return 0;
      end
      return for_post ? post_decay[gap] : pre_decay[gap];
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_PLASTIC_ENABLE: learn     = d[0];
        REG_WEIGHT_MAX:     w_ceiling = d;
        REG_WEIGHT_MIN:     w_floor   = d;
        REG_AMP_POS:        amp_pre   = d;
        REG_AMP_NEG:        amp_post  = d;
        REG_DRIFT_CONST:    drift     = d;
        REG_CHANGE_FILTER:  filter    = d[16:0];
        default: ;
      endcase
    endfunction

    function void predict_event(logic [1:0] k, logic [SYN_W-1:0] s, logic [31:0] now,
                                logic signed [31:0] load_w);
      delivery_t          res;
      logic signed [31:0] tr;
      logic [31:0]        gap;
      longint             w;
      res.row    = s;
      res.dlv    = 1'b0;
      res.amount = '0;
      case (k)
        KIND_PRE: begin
          res.dlv    = 1'b1;
          res.amount = weight[s];
          if (learn) begin
            gap            = now - post_stamp[s];
            tr             = scale(post_trace[s], decay_at(1'b1, gap));
            post_trace[s]  = tr;
            change[s]      = clip(longint'(change[s]) + longint'(tr));
            pre_trace[s]   = amp_pre;
            pre_stamp[s]   = now;
          end
        end
        KIND_POST: begin
          if (learn) begin
            gap            = now - pre_stamp[s];
            tr             = scale(pre_trace[s], decay_at(1'b0, gap));
            pre_trace[s]   = tr;
            change[s]      = clip(longint'(change[s]) + longint'(tr));
            post_trace[s]  = amp_post;
            post_stamp[s]  = now;
          end
        end
        KIND_UPDATE: begin
          if (learn) begin
            w = longint'(weight[s]) + longint'(change[s]) + longint'(drift);
            if (w > longint'(w_ceiling)) begin
              w = w_ceiling;
            end else if (w < longint'(w_floor)) begin
              w = w_floor;
            end
            weight[s] = clip(w);
            change[s] = scale(change[s], (filter > FILTER_ONE) ? 32'd65536 : filter);
          end
        end
        default: begin
          weight[s]     = load_w;
          change[s]     = '0;
          pre_trace[s]  = '0;
          post_trace[s] = '0;
          pre_stamp[s]  = now;
          post_stamp[s] = now;
        end
      endcase
      expected_deliveries.insert(expected_deliveries.size(), res);
    endfunction

    function int pending();
      return expected_deliveries.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endtask

    task check_delivery(logic [SYN_W-1:0] s, logic dlv, logic signed [31:0] amount);
      delivery_t want;
      if (expected_deliveries.size() == 0) begin
        report_mismatch($sformatf("result for synapse %0d with nothing outstanding", s));
        return;
      end
      want = expected_deliveries.pop_front();
      if (s !== want.row) begin
        report_mismatch($sformatf("synapse_out %0d, want %0d", s, want.row));
      end
      if (dlv !== want.dlv) begin
        report_mismatch($sformatf("synapse %0d: delivers %b, want %b", want.row, dlv,
                                  want.dlv));
      end
      if (amount !== want.amount) begin
        report_mismatch($sformatf("synapse %0d: current_add %0d, want %0d", want.row,
                                  amount, want.amount));
      end
    endtask
  endclass

  logic               clk;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [1:0]         kind        = KIND_PRE;
  logic [SYN_W-1:0]   synapse     = '0;
  logic [31:0]        event_time  = '0;
  logic signed [31:0] load_weight = '0;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index   = REG_PLASTIC_ENABLE;
  logic [31:0]        cfg_data    = '0;
  logic               done;
  logic [SYN_W-1:0]   synapse_out;
  logic               delivers;
  logic signed [31:0] current_add;

  synapse_table_tracker tracker;
  int                   idle_pct     = 32;
  int                   sent         = 0;
  int                   stall_cycles = 0;
  bit                   row_loaded [SYNAPSES];
  logic [SYN_W-1:0]     hot_rows [8];
  logic [31:0]          tick_now = 32'd3000;
  setting_t             phase_plan [8] = '{SET_TYPICAL, SET_EXTREME_HIGH, SET_INVERTED_CLAMP,
                                           SET_LEARNING_OFF, SET_EXTREME_LOW, SET_ANY,
                                           SET_TYPICAL, SET_ANY};

  stdp_synapse_table_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .synapse     (synapse),
    .event_time  (event_time),
    .load_weight (load_weight),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .synapse_out (synapse_out),
    .delivers    (delivers),
    .current_add (current_add)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample every transfer at the edge that completes it; outputs and driven
  // inputs still hold their pre-edge values here since both change by NBA.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        tracker.predict_event(kind, synapse, event_time, load_weight);
      end
      if (cfg_valid && cfg_ready) begin
        tracker.set_register(cfg_index, cfg_data);
      end
      if (done) begin
        tracker.check_delivery(synapse_out, delivers, current_add);
      end
    end
  end

  // Hang detection: restart the count on any transfer.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("** stdp_synapse_table_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command and hold it until the transfer. Idle first at the
  // current rate, keeping start low through the gap. Start is left high so
  // back-to-back commands never lower and raise it in one step.
  task automatic send_command(input logic [1:0] k, input logic [SYN_W-1:0] s,
                              input logic [31:0] t, input logic signed [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    kind        <= k;
    synapse     <= s;
    event_time  <= t;
    load_weight <= w;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // Drop start, then wait until every result is in and the block is free.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  // Hold one register write until the transfer; the caller drops valid.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [SYN_W-1:0]   row;
    logic [1:0]         k;
    logic [31:0]        t;
    logic signed [31:0] w;
    int unsigned        roll;
    logic [31:0]        pe, wmax, wmin, ap, an, dr, cf;

    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part under reset register values.
    // Load both end rows with the extreme weights and times.
    send_command(KIND_LOAD, 10'd0, 32'd0, 32'sh7FFF_FFFF);
    send_command(KIND_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_command(KIND_PRE, 10'd0, 32'd5, '0);
    send_command(KIND_POST, 10'd0, 32'd10, '0);
    send_command(KIND_PRE, 10'd0, 32'd10, '0);       // zero elapsed time
    send_command(KIND_UPDATE, 10'd0, 32'd10, '0);    // weight above the ceiling
    send_command(KIND_PRE, 10'd0, 32'd11, '0);
    send_command(KIND_PRE, 10'd1023, 32'hFFFF_FFFF, '0);
    send_command(KIND_POST, 10'd1023, 32'd3, '0);    // time wraps past zero
    send_command(KIND_PRE, 10'd1023, 32'd1, '0);     // time runs backwards
    send_command(KIND_UPDATE, 10'd1023, 32'd1, '0);  // weight below the floor
    send_command(KIND_POST, 10'd0, 32'd1034, '0);    // last decay table entry
    send_command(KIND_PRE, 10'd0, 32'd2058, '0);     // just past the table
    send_command(KIND_PRE, 10'd1023, 32'd2, '0);
    row_loaded[0]    = 1'b1;
    row_loaded[1023] = 1'b1;

    // Learning off: spikes deliver only, updates do nothing, loads still act.
    wait_idle();
    write_register(REG_PLASTIC_ENABLE, 32'd0);
    cfg_valid <= 1'b0;
    send_command(KIND_PRE, 10'd0, 32'd2060, '0);
    send_command(KIND_POST, 10'd0, 32'd2061, '0);
    send_command(KIND_UPDATE, 10'd0, 32'd2061, '0);
    send_command(KIND_LOAD, 10'd5, 32'd2062, 32'sd12345);
    send_command(KIND_PRE, 10'd5, 32'd2063, '0);
    wait_idle();
    write_register(REG_PLASTIC_ENABLE, 32'd1);
    cfg_valid <= 1'b0;
    send_command(KIND_PRE, 10'd5, 32'd2064, '0);
    send_command(KIND_UPDATE, 10'd5, 32'd2064, '0);
    row_loaded[5] = 1'b1;

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      pe   = $urandom() | 32'd1;
      wmax = $urandom_range(65536, 1048576);
      wmin = 32'd0 - $urandom_range(0, 262144);
      ap   = $urandom_range(0, 65536);
      an   = 32'd0 - $urandom_range(0, 65536);
      dr   = $urandom_range(0, 2000) - 32'd1000;
      cf   = {15'($urandom()), 17'($urandom_range(0, 65536))};
      case (phase_plan[p])
        SET_EXTREME_HIGH: begin
          pe   = 32'hFFFF_FFFF;
          wmax = 32'h7FFF_FFFF;
          wmin = 32'h8000_0000;
          ap   = 32'h7FFF_FFFF;
          an   = 32'h8000_0000;
          dr   = 32'h7FFF_FFFF;
          cf   = 32'hFFFF_FFFF;    // filter beyond 1.0
        end
        SET_EXTREME_LOW: begin
          wmax = 32'h7FFF_FFFF;
          wmin = 32'h8000_0000;
          ap   = 32'h8000_0000;
          an   = 32'h7FFF_FFFF;
          dr   = 32'h8000_0000;
          cf   = {15'($urandom()), 17'd0};
        end
        SET_INVERTED_CLAMP: begin
          // floor above ceiling: the ceiling wins
          wmax = 32'd0 - $urandom_range(0, 65536);
          wmin = $urandom_range(1, 65536);
          cf   = {15'($urandom()), FILTER_ONE};
        end
        SET_LEARNING_OFF: begin
          pe = $urandom() & ~32'd1;
        end
        SET_ANY: begin
          pe   = $urandom();
          wmax = $urandom();
          wmin = $urandom();
          ap   = $urandom();
          an   = $urandom();
          dr   = $urandom();
          cf   = $urandom();
        end
        default: ;
      endcase
      wait_idle();
      write_register(REG_PLASTIC_ENABLE, pe);
      write_register(REG_WEIGHT_MAX, wmax);
      write_register(REG_WEIGHT_MIN, wmin);
      write_register(REG_AMP_POS, ap);
      write_register(REG_AMP_NEG, an);
      write_register(REG_DRIFT_CONST, dr);
      write_register(REG_CHANGE_FILTER, cf);
      cfg_valid <= 1'b0;

      // Concentrate traffic on a few rows so spikes pair up within the table.
      foreach (hot_rows[i]) begin
        hot_rows[i] = SYN_W'($urandom_range(SYNAPSES - 1));
      end

      repeat (ITEMS_PER_PHASE) begin
        idle_pct = (sent < 500) ? 32 : (sent < 1000) ? 68 : 0;
        row = ($urandom_range(99) < 85) ? hot_rows[$urandom_range(7)]
                                        : SYN_W'($urandom_range(SYNAPSES - 1));
        // Never touch a row before a load has written it.
        roll = $urandom_range(99);
        if (!row_loaded[row] || roll < 8) begin
          k = KIND_LOAD;
        end else if (roll < 45) begin
          k = KIND_PRE;
        end else if (roll < 80) begin
          k = KIND_POST;
        end else begin
          k = KIND_UPDATE;
        end
        // Advance time mostly in small steps; now and then jump or go stale.
        roll = $urandom_range(99);
        if (roll < 3) begin
          tick_now = $urandom();
        end else if (roll < 6) begin
          tick_now = tick_now + $urandom_range(1024, 5000);
        end else begin
          tick_now = tick_now + $urandom_range(0, 40);
        end
        t = tick_now;
        if ($urandom_range(99) < 3) begin
          t = tick_now - $urandom_range(1, 60);
        end
        if ($urandom_range(1) == 1) begin
          w = $urandom();
        end else begin
          w = $urandom_range(0, 262143) - 32'd131072;
        end
        if (k == KIND_LOAD) begin
          row_loaded[row] = 1'b1;
        end
        send_command(k, row, t, w);
      end
    end

    // Drain, then allow a few more cycles for any stray result.
    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("** stdp_synapse_table_unit: PASSED **");
    end else begin
      $display("** stdp_synapse_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/stdp_pkg.sv
rtl/core/stdp_decay_rom.sv
rtl/core/stdp_scale_unit.sv
rtl/core/stdp_synapse_table_unit.sv
test/stdp_synapse_table_unit_tb.sv
